FILE: sv/rbbf_pkg.sv
// Shared types, widths and codes for the RGB box blur filter.
package rbbf_pkg;

    localparam int MAX_WIDTH_DEF  = 512;
    localparam int MAX_RADIUS_DEF = 7;

    localparam int PIX_W      = 24;
    localparam int NCH        = 3;
    localparam int COL_W      = 10;
    localparam int ROW_W      = 11;
    localparam int HGT_W      = 10;
    localparam int WS_W       = 4;
    localparam int RAD_W      = 3;
    localparam int WIN_W      = 4;
    localparam int CNT_W      = 21;
    localparam int LAG_W      = 14;
    localparam int SUM_W      = 16;
    localparam int DIV_W      = 8;
    localparam int DCNT_W     = 4;
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 10;

    localparam logic [COL_W-1:0] WIDTH_RST  = 10'd512;
    localparam logic [HGT_W-1:0] HEIGHT_RST = 10'd512;
    localparam logic [WS_W-1:0]  WINDOW_RST = 4'd3;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_WIDTH  = 2'd0,
        CFG_HEIGHT = 2'd1,
        CFG_WINDOW = 2'd2
    } cfg_idx_t;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_START,
        ST_BACK,
        ST_SUM,
        ST_SETTLE,
        ST_DIV,
        ST_DONE
    } state_t;

    typedef struct packed {
        logic [NCH-1:0][SUM_W-1:0] num;
        logic [NCH-1:0][DIV_W-1:0] rem;
        logic [NCH-1:0][SUM_W-1:0] quo;
        logic [DIV_W-1:0]          dvs;
    } div_cell_t;

endpackage

FILE: sv/rbbf_div_cell.sv
// One restoring-division cell: retires one quotient bit per channel and hands on.
module rbbf_div_cell (
    input  logic                aclk,
    input  logic                en,
    input  rbbf_pkg::div_cell_t cell_in,
    output rbbf_pkg::div_cell_t cell_out
);

    rbbf_pkg::div_cell_t cell_reg;
    rbbf_pkg::div_cell_t cell_next;
    logic [rbbf_pkg::NCH-1:0][rbbf_pkg::DIV_W:0] rem_sh;
    logic [rbbf_pkg::NCH-1:0]                    ge;

    always_comb begin
        cell_next     = cell_in;
        for (int ch = 0; ch < rbbf_pkg::NCH; ch++) begin
            rem_sh[ch] = {cell_in.rem[ch], cell_in.num[ch][rbbf_pkg::SUM_W-1]};
            ge[ch]     = rem_sh[ch] >= {1'b0, cell_in.dvs};
            cell_next.rem[ch] = ge[ch]
                ? rbbf_pkg::DIV_W'(rem_sh[ch] - {1'b0, cell_in.dvs})
                : rbbf_pkg::DIV_W'(rem_sh[ch]);
            cell_next.quo[ch] = {cell_in.quo[ch][rbbf_pkg::SUM_W-2:0], ge[ch]};
            cell_next.num[ch] = {cell_in.num[ch][rbbf_pkg::SUM_W-2:0], 1'b0};
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            cell_reg <= cell_next;
        end
    end

    assign cell_out = cell_reg;

endmodule

FILE: sv/rgb_box_blur_filter_core.sv
// Streaming RGB box blur: a pixel with no pending result is taken while the core stays idle;
// a pixel or flush request that releases a result steps through START, BACK, SUM over the
// clipped window, SETTLE, DIV in the 16-cell divider chain, then DONE until the output is free;
// the single read port sweeps the window one pixel per cycle; no memory clearing pass is run.
module rgb_box_blur_filter_core #(
    parameter int MAX_WIDTH  = rbbf_pkg::MAX_WIDTH_DEF,
    parameter int MAX_RADIUS = rbbf_pkg::MAX_RADIUS_DEF
) (
    input  logic                            aclk,
    input  logic                            aresetn,
    input  logic                            s_tvalid,
    output logic                            s_tready,
    input  logic [rbbf_pkg::PIX_W-1:0]      s_tdata,   // red_in, green_in, blue_in
    input  logic                            s_tuser,   // func
    output logic                            m_tvalid,
    input  logic                            m_tready,
    output logic [rbbf_pkg::PIX_W-1:0]      m_tdata,   // red_out, green_out, blue_out
    output logic                            m_tlast,
    input  logic                            cfg_valid,
    output logic                            cfg_ready,
    input  logic [rbbf_pkg::CFG_IDX_W-1:0]  cfg_index,
    input  logic [rbbf_pkg::CFG_DATA_W-1:0] cfg_data
);

    localparam int LD     = (2 * MAX_RADIUS + 1) * MAX_WIDTH;
    localparam int ADDR_W = $clog2(LD);
    localparam int RMAX   = (MAX_RADIUS < (MAX_WIDTH - 1) / 2) ? MAX_RADIUS
                                                               : (MAX_WIDTH - 1) / 2;

    function automatic logic [ADDR_W-1:0] addr_add(input logic [ADDR_W-1:0] a,
                                                   input logic [ADDR_W-1:0] b);
        logic [ADDR_W:0] s;
        s = {1'b0, a} + {1'b0, b};
        if (s >= (ADDR_W+1)'(LD)) begin
            s = s - (ADDR_W+1)'(LD);
        end
        return s[ADDR_W-1:0];
    endfunction

    function automatic logic [ADDR_W-1:0] addr_sub(input logic [ADDR_W-1:0] a,
                                                   input logic [ADDR_W-1:0] b);
        logic [ADDR_W:0] s;
        if (a >= b) begin
            s = {1'b0, a} - {1'b0, b};
        end else begin
            s = {1'b0, a} + (ADDR_W+1)'(LD) - {1'b0, b};
        end
        return s[ADDR_W-1:0];
    endfunction

    rbbf_pkg::state_t state_reg, state_next;

    logic [rbbf_pkg::COL_W-1:0] width_reg;
    logic [rbbf_pkg::HGT_W-1:0] height_reg;
    logic [rbbf_pkg::WS_W-1:0]  window_reg;

    logic [rbbf_pkg::ROW_W-1:0] in_row_reg, out_row_reg;
    logic [rbbf_pkg::COL_W-1:0] in_col_reg, out_col_reg;
    logic [rbbf_pkg::CNT_W-1:0] cnt_reg;
    logic [ADDR_W-1:0]          wr_ptr_reg, out_ptr_reg;

    logic [rbbf_pkg::RAD_W-1:0]  rows_back_reg;
    logic [rbbf_pkg::WIN_W-1:0]  row_cnt_reg, col_cnt_reg, nrows_m1_reg, ncols_m1_reg;
    logic [rbbf_pkg::DCNT_W-1:0] div_cnt_reg;
    logic                        rd_valid_reg;
    logic                        m_tvalid_reg;

    logic [ADDR_W-1:0]                           addr_reg, row_base_reg;
    logic [rbbf_pkg::NCH-1:0][rbbf_pkg::SUM_W-1:0] acc_reg;
    logic [rbbf_pkg::PIX_W-1:0]                  rd_data_reg;
    logic                                        last_reg;
    logic [rbbf_pkg::PIX_W-1:0]                  m_tdata_reg;
    logic                                        m_tlast_reg;

    logic [rbbf_pkg::PIX_W-1:0] mem [LD];

    logic [rbbf_pkg::COL_W-1:0] w_eff;
    logic [rbbf_pkg::HGT_W-1:0] h_eff;
    logic [rbbf_pkg::WS_W-1:0]  ws_eff;
    logic [rbbf_pkg::RAD_W-1:0] half, rad;
    logic [rbbf_pkg::DIV_W-1:0] dvs;
    logic [rbbf_pkg::LAG_W-1:0] lag;

    logic                       s_acc, cfg_acc, in_done, take, need, out_free, div_en;
    logic [rbbf_pkg::CNT_W-1:0] cnt_inc;

    logic [rbbf_pkg::RAD_W-1:0] rows_back, cols_back;
    logic [rbbf_pkg::ROW_W:0]   row_top;
    logic [rbbf_pkg::COL_W:0]   col_top;
    logic [rbbf_pkg::ROW_W-1:0] row_hi;
    logic [rbbf_pkg::COL_W-1:0] col_hi;
    logic [ADDR_W-1:0]          start_addr, w_addr;
    logic                       last_pix, sum_end;

    rbbf_pkg::div_cell_t link [rbbf_pkg::SUM_W+1];

    assign w_eff  = (width_reg == '0) ? rbbf_pkg::COL_W'(1)
                  : ((int'(width_reg) > MAX_WIDTH) ? rbbf_pkg::COL_W'(MAX_WIDTH) : width_reg);
    assign h_eff  = (height_reg == '0) ? rbbf_pkg::HGT_W'(1) : height_reg;
    assign ws_eff = (window_reg == '0) ? rbbf_pkg::WS_W'(1) : window_reg;
    assign half   = rbbf_pkg::RAD_W'(ws_eff >> 1);
    assign rad    = (int'(half) > RMAX) ? rbbf_pkg::RAD_W'(RMAX) : half;
    assign dvs    = rbbf_pkg::DIV_W'(ws_eff * ws_eff);
    assign lag    = rbbf_pkg::LAG_W'(rad * w_eff) + rbbf_pkg::LAG_W'(rad);
    assign w_addr = ADDR_W'(w_eff);

    assign s_acc   = s_tvalid && s_tready;
    assign cfg_acc = cfg_valid && cfg_ready;
    assign in_done = in_row_reg >= rbbf_pkg::ROW_W'(h_eff);
    assign take    = s_tuser ? in_done : !in_done;
    assign cnt_inc = cnt_reg + rbbf_pkg::CNT_W'(1);
    assign need    = cnt_inc > rbbf_pkg::CNT_W'(lag);

    assign rows_back = (out_row_reg >= rbbf_pkg::ROW_W'(rad)) ? rad
                                                             : rbbf_pkg::RAD_W'(out_row_reg);
    assign cols_back = (out_col_reg >= rbbf_pkg::COL_W'(rad)) ? rad
                                                             : rbbf_pkg::RAD_W'(out_col_reg);
    assign row_top   = {1'b0, out_row_reg} + (rbbf_pkg::ROW_W+1)'(rad);
    assign col_top   = {1'b0, out_col_reg} + (rbbf_pkg::COL_W+1)'(rad);
    assign row_hi    = (row_top < (rbbf_pkg::ROW_W+1)'(h_eff)) ? rbbf_pkg::ROW_W'(row_top)
                                                              : rbbf_pkg::ROW_W'(h_eff - 1'b1);
    assign col_hi    = (col_top < (rbbf_pkg::COL_W+1)'(w_eff)) ? rbbf_pkg::COL_W'(col_top)
                                                              : w_eff - 1'b1;
    assign start_addr = addr_sub(out_ptr_reg, ADDR_W'(cols_back));
    assign last_pix   = (out_row_reg == rbbf_pkg::ROW_W'(h_eff - 1'b1))
                     && (out_col_reg == w_eff - 1'b1);
    assign sum_end    = (col_cnt_reg == ncols_m1_reg) && (row_cnt_reg == nrows_m1_reg);

    always_comb begin
        state_next = state_reg;
        unique case (state_reg)
            rbbf_pkg::ST_IDLE: begin
                if (s_acc && take && need) begin
                    state_next = rbbf_pkg::ST_START;
                end
            end
            rbbf_pkg::ST_START:  state_next = rbbf_pkg::ST_BACK;
            rbbf_pkg::ST_BACK: begin
                if (rows_back_reg == '0) begin
                    state_next = rbbf_pkg::ST_SUM;
                end
            end
            rbbf_pkg::ST_SUM: begin
                if (sum_end) begin
                    state_next = rbbf_pkg::ST_SETTLE;
                end
            end
            rbbf_pkg::ST_SETTLE: state_next = rbbf_pkg::ST_DIV;
            rbbf_pkg::ST_DIV: begin
                if (div_cnt_reg == rbbf_pkg::DCNT_W'(rbbf_pkg::SUM_W - 1)) begin
                    state_next = rbbf_pkg::ST_DONE;
                end
            end
            rbbf_pkg::ST_DONE: begin
                if (out_free) begin
                    state_next = rbbf_pkg::ST_IDLE;
                end
            end
            default: state_next = rbbf_pkg::ST_IDLE;
        endcase
    end

    always_comb begin
        s_tready  = (state_reg == rbbf_pkg::ST_IDLE) && !cfg_valid;
        cfg_ready = (state_reg == rbbf_pkg::ST_IDLE);
        div_en    = (state_reg == rbbf_pkg::ST_DIV);
        out_free  = !m_tvalid_reg || m_tready;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg     <= rbbf_pkg::ST_IDLE;
            width_reg     <= rbbf_pkg::WIDTH_RST;
            height_reg    <= rbbf_pkg::HEIGHT_RST;
            window_reg    <= rbbf_pkg::WINDOW_RST;
            in_row_reg    <= '0;
            in_col_reg    <= '0;
            out_row_reg   <= '0;
            out_col_reg   <= '0;
            cnt_reg       <= '0;
            wr_ptr_reg    <= '0;
            out_ptr_reg   <= '0;
            rows_back_reg <= '0;
            row_cnt_reg   <= '0;
            col_cnt_reg   <= '0;
            nrows_m1_reg  <= '0;
            ncols_m1_reg  <= '0;
            div_cnt_reg   <= '0;
            rd_valid_reg  <= 1'b0;
            m_tvalid_reg  <= 1'b0;
        end else begin
            state_reg    <= state_next;
            rd_valid_reg <= (state_reg == rbbf_pkg::ST_SUM);
            if (m_tvalid_reg && m_tready) begin
                m_tvalid_reg <= 1'b0;
            end
            if (cfg_acc) begin
                unique case (rbbf_pkg::cfg_idx_t'(cfg_index))
                    rbbf_pkg::CFG_WIDTH:  width_reg  <= cfg_data;
                    rbbf_pkg::CFG_HEIGHT: height_reg <= cfg_data;
                    rbbf_pkg::CFG_WINDOW: window_reg <= cfg_data[rbbf_pkg::WS_W-1:0];
                    default: ;
                endcase
                if (cfg_index == rbbf_pkg::CFG_WIDTH || cfg_index == rbbf_pkg::CFG_HEIGHT
                        || cfg_index == rbbf_pkg::CFG_WINDOW) begin
                    in_row_reg  <= '0;
                    in_col_reg  <= '0;
                    out_row_reg <= '0;
                    out_col_reg <= '0;
                    cnt_reg     <= '0;
                    wr_ptr_reg  <= '0;
                    out_ptr_reg <= '0;
                end
            end
            unique case (state_reg)
                rbbf_pkg::ST_IDLE: begin
                    if (s_acc && take) begin
                        cnt_reg    <= cnt_inc;
                        wr_ptr_reg <= addr_add(wr_ptr_reg, ADDR_W'(1));
                        if (in_col_reg == w_eff - 1'b1) begin
                            in_col_reg <= '0;
                            in_row_reg <= in_row_reg + 1'b1;
                        end else begin
                            in_col_reg <= in_col_reg + 1'b1;
                        end
                    end
                end
                rbbf_pkg::ST_START: begin
                    rows_back_reg <= rows_back;
                    nrows_m1_reg  <= rbbf_pkg::WIN_W'(row_hi - (out_row_reg
                                     - rbbf_pkg::ROW_W'(rows_back)));
                    ncols_m1_reg  <= rbbf_pkg::WIN_W'(col_hi - (out_col_reg
                                     - rbbf_pkg::COL_W'(cols_back)));
                    row_cnt_reg   <= '0;
                    col_cnt_reg   <= '0;
                    div_cnt_reg   <= '0;
                    if (last_pix) begin
                        in_row_reg  <= '0;
                        in_col_reg  <= '0;
                        out_row_reg <= '0;
                        out_col_reg <= '0;
                        cnt_reg     <= '0;
                        wr_ptr_reg  <= '0;
                        out_ptr_reg <= '0;
                    end else begin
                        out_ptr_reg <= addr_add(out_ptr_reg, ADDR_W'(1));
                        if (out_col_reg == w_eff - 1'b1) begin
                            out_col_reg <= '0;
                            out_row_reg <= out_row_reg + 1'b1;
                        end else begin
                            out_col_reg <= out_col_reg + 1'b1;
                        end
                    end
                end
                rbbf_pkg::ST_BACK: begin
                    if (rows_back_reg != '0) begin
                        rows_back_reg <= rows_back_reg - 1'b1;
                    end
                end
                rbbf_pkg::ST_SUM: begin
                    if (col_cnt_reg == ncols_m1_reg) begin
                        col_cnt_reg <= '0;
                        row_cnt_reg <= row_cnt_reg + 1'b1;
                    end else begin
                        col_cnt_reg <= col_cnt_reg + 1'b1;
                    end
                end
                rbbf_pkg::ST_DIV: begin
                    div_cnt_reg <= div_cnt_reg + 1'b1;
                end
                rbbf_pkg::ST_DONE: begin
                    if (out_free) begin
                        m_tvalid_reg <= 1'b1;
                    end
                end
                default: ;
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        unique case (state_reg)
            rbbf_pkg::ST_START: begin
                addr_reg     <= start_addr;
                row_base_reg <= start_addr;
                last_reg     <= last_pix;
            end
            rbbf_pkg::ST_BACK: begin
                if (rows_back_reg != '0) begin
                    addr_reg     <= addr_sub(addr_reg, w_addr);
                    row_base_reg <= addr_sub(row_base_reg, w_addr);
                end
            end
            rbbf_pkg::ST_SUM: begin
                if (col_cnt_reg == ncols_m1_reg) begin
                    row_base_reg <= addr_add(row_base_reg, w_addr);
                    addr_reg     <= addr_add(row_base_reg, w_addr);
                end else begin
                    addr_reg <= addr_add(addr_reg, ADDR_W'(1));
                end
            end
            rbbf_pkg::ST_DONE: begin
                if (out_free) begin
                    for (int ch = 0; ch < rbbf_pkg::NCH; ch++) begin
                        m_tdata_reg[ch*8 +: 8] <= (|link[rbbf_pkg::SUM_W].quo[ch][rbbf_pkg::SUM_W-1:8])
                            ? 8'hFF : link[rbbf_pkg::SUM_W].quo[ch][7:0];
                    end
                    m_tlast_reg <= last_reg;
                end
            end
            default: ;
        endcase
        if (state_reg == rbbf_pkg::ST_START) begin
            acc_reg <= '0;
        end else if (rd_valid_reg) begin
            for (int ch = 0; ch < rbbf_pkg::NCH; ch++) begin
                acc_reg[ch] <= acc_reg[ch] + rbbf_pkg::SUM_W'(rd_data_reg[ch*8 +: 8]);
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (s_acc && take && !s_tuser) begin
            mem[wr_ptr_reg] <= s_tdata;
        end
        rd_data_reg <= mem[addr_reg];
    end

    always_comb begin
        link[0].num = acc_reg;
        link[0].rem = '0;
        link[0].quo = '0;
        link[0].dvs = dvs;
    end

    for (genvar i = 0; i < rbbf_pkg::SUM_W; i++) begin : g_cell
        rbbf_div_cell u_cell (
            .aclk     (aclk),
            .en       (div_en),
            .cell_in  (link[i]),
            .cell_out (link[i+1])
        );
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = m_tdata_reg;
    assign m_tlast  = m_tlast_reg;

endmodule

FILE: sv/rbbf_checker.sv
// Port-level assertions for the RGB box blur filter core, bound to the top level.
module rbbf_checker (
    input logic                            aclk,
    input logic                            aresetn,
    input logic                            s_tready,
    input logic                            m_tvalid,
    input logic                            m_tready,
    input logic [rbbf_pkg::PIX_W-1:0]      m_tdata,
    input logic                            m_tlast,
    input logic                            cfg_valid,
    input logic                            cfg_ready
);

    a_reset_clears: assert property (@(posedge aclk) !aresetn |=> !m_tvalid)
        else $error("result valid after reset");

    a_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tlast))
        else $error("stalled result changed");

    a_cfg_excl: assert property (@(posedge aclk) disable iff (!aresetn)
        !(s_tready && cfg_valid))
        else $error("input request taken alongside configuration write");

    a_result_busy: assert property (@(posedge aclk) disable iff (!aresetn)
        $rose(m_tvalid) |-> !$past(s_tready) && !$past(cfg_ready))
        else $error("result produced while idle");

endmodule

bind rgb_box_blur_filter_core rbbf_checker u_rbbf_checker (
    .aclk      (aclk),
    .aresetn   (aresetn),
    .s_tready  (s_tready),
    .m_tvalid  (m_tvalid),
    .m_tready  (m_tready),
    .m_tdata   (m_tdata),
    .m_tlast   (m_tlast),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready)
);
